/* hdl/ffba_pkg.sv */
package ffba_pkg;

    localparam int DEF_NUM_TYPES  = 32;
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_BLOCK_SIZE = 268435456;

    localparam int TYPE_W   = 5;
    localparam int ALIGN_W  = 17;
    localparam int MASK_W   = 16;
    localparam int REQ_W    = 29;
    localparam int INDEX_W  = 4;
    localparam int OFFSET_W = 28;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Classified request as it waits between the front and the back.
    typedef struct packed {
        logic [TYPE_W-1:0] mem_type;
        logic [MASK_W-1:0] align_mask;
        logic [REQ_W-1:0]  size;
        logic              fail;
    } req_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  block_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic                opened_block;
        logic                failed;
    } result_t;

endpackage

/* hdl/ffba_ram.sv */
module ffba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/ffba_queue.sv */
module ffba_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ffba_pkg::req_t  push_data,
    input  logic            pop,
    output ffba_pkg::req_t  head,
    output ffba_pkg::q_stat_t stat
);

    import ffba_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);

endmodule

/* hdl/ffba_front.sv */
module ffba_front #(
    parameter int NUM_TYPES  = ffba_pkg::DEF_NUM_TYPES,
    parameter int BLOCK_SIZE = ffba_pkg::DEF_BLOCK_SIZE
) (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  ffba_pkg::q_stat_t                q_stat,
    output logic                             push,
    output ffba_pkg::req_t                   push_data
);

    import ffba_pkg::*;

    localparam logic [TYPE_W:0] TYPE_LIMIT = (TYPE_W + 1)'(NUM_TYPES);
    localparam logic [31:0]     SIZE_LIMIT = 32'(BLOCK_SIZE);

    logic [TYPE_W-1:0]  mem_type;
    logic [ALIGN_W-1:0] alignment;
    logic [REQ_W-1:0]   request_bytes;
    logic [ALIGN_W-1:0] smear;
    logic [REQ_W-1:0]   size;

    assign mem_type      = s_tdata[TYPE_W-1:0];
    assign alignment     = s_tdata[TYPE_W+ALIGN_W-1:TYPE_W];
    assign request_bytes = s_tdata[TYPE_W+ALIGN_W+REQ_W-1:TYPE_W+ALIGN_W];

    // Spreading the top set bit downwards gives the mask of the largest power
    // of two not above the alignment; a zero alignment yields an empty mask.
    always_comb begin
        smear = alignment;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
    end

    assign size = (request_bytes == '0) ? REQ_W'(1) : request_bytes;

    assign push_data.mem_type   = mem_type;
    assign push_data.align_mask = smear[ALIGN_W-1:1];
    assign push_data.size       = size;
    assign push_data.fail       = ({1'b0, mem_type} >= TYPE_LIMIT)
                                  || (32'(size) > SIZE_LIMIT);

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

endmodule

/* hdl/ffba_back.sv */
module ffba_back #(
    parameter int NUM_TYPES  = ffba_pkg::DEF_NUM_TYPES,
    parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_SIZE = ffba_pkg::DEF_BLOCK_SIZE
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffba_pkg::q_stat_t q_stat,
    input  ffba_pkg::req_t    q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output ffba_pkg::result_t m_result
);

    import ffba_pkg::*;

    localparam int PTR_W  = $clog2(BLOCK_SIZE + 1);
    localparam int SUM_W  = ((PTR_W > MASK_W) ? PTR_W : MASK_W) + 1;
    localparam int CHK_W  = ((SUM_W > REQ_W) ? SUM_W : REQ_W) + 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int LANE_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int ROW_W  = MAX_BLOCKS * PTR_W;

    localparam logic [CHK_W-1:0] LIMIT    = CHK_W'(BLOCK_SIZE);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BLOCKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_WR   = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    req_t                  req_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      cnt_reg [NUM_TYPES];
    logic [MAX_BLOCKS-1:0] ok_reg;
    logic [MAX_BLOCKS-1:0] ok_next;
    logic [SUM_W-1:0]      aligned_reg  [MAX_BLOCKS];
    logic [SUM_W-1:0]      aligned_next [MAX_BLOCKS];
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;

    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      wr_row;
    logic                  wr_en;
    logic                  rd_en;
    logic [TIDX_W-1:0]     tidx;
    logic [CNT_W-1:0]      used_now;
    logic [SUM_W-1:0]      mask_ext;
    logic                  finish;
    logic                  hit;
    logic                  full;
    logic                  fail;
    logic [LANE_W-1:0]     sel;
    logic [LANE_W-1:0]     wr_lane;
    logic [PTR_W-1:0]      wr_ptr;
    logic [SUM_W-1:0]      aligned_sel;
    logic [CHK_W-1:0]      end_sel;
    logic [LANE_W+3:0]     lane_ext;
    logic [SUM_W+27:0]     off_ext;

    assign tidx     = req_reg.mem_type[TIDX_W-1:0];
    assign used_now = req_reg.fail ? '0 : cnt_reg[tidx];
    assign mask_ext = SUM_W'(req_reg.align_mask);

    // Every block of the type is rounded up and checked against the block
    // end in parallel; only blocks already in use take part.
    always_comb begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            aligned_next[i] = (SUM_W'(rd_row[i*PTR_W +: PTR_W]) + mask_ext) & ~mask_ext;
            ok_next[i] = (CNT_W'(i) < used_now)
                         && ((CHK_W'(aligned_next[i]) + CHK_W'(req_reg.size)) <= LIMIT);
        end
    end

    always_comb begin
        sel = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (ok_reg[i]) begin
                sel = LANE_W'(i);
            end
        end
    end

    assign hit         = |ok_reg;
    assign full        = (used_reg == FULL_CNT);
    assign fail        = req_reg.fail || (!hit && full);
    assign aligned_sel = aligned_reg[sel];
    assign end_sel     = CHK_W'(aligned_sel) + CHK_W'(req_reg.size);
    assign wr_lane     = hit ? sel : used_reg[LANE_W-1:0];
    assign wr_ptr      = hit ? PTR_W'(end_sel) : PTR_W'(req_reg.size);
    assign lane_ext    = (LANE_W + 4)'(wr_lane);
    assign off_ext     = (SUM_W + 28)'(aligned_sel);

    always_comb begin
        wr_row = rd_row;
        wr_row[wr_lane*PTR_W +: PTR_W] = wr_ptr;
    end

    assign finish = (state_reg == S_WR) && (!out_valid_reg || m_ready);
    assign wr_en  = finish && !fail;
    assign rd_en  = (state_reg == S_IDLE) && q_stat.valid;
    assign q_pop  = rd_en;

    always_comb begin
        out_next = out_reg;
        if (finish) begin
            if (fail) begin
                out_next = '0;
                out_next.failed = 1'b1;
            end else begin
                out_next.block_index  = lane_ext[INDEX_W-1:0];
                out_next.byte_offset  = hit ? off_ext[OFFSET_W-1:0] : '0;
                out_next.opened_block = !hit;
                out_next.failed       = 1'b0;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        case (state_reg)
            S_IDLE:  state_next = q_stat.valid ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_WR;
            S_WR:    state_next = finish ? S_IDLE : S_WR;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TYPES; t++) begin
                cnt_reg[t] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish && !fail && !hit) begin
                cnt_reg[tidx] <= used_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (rd_en) begin
            req_reg <= q_head;
        end
        if (state_reg == S_CMP) begin
            used_reg <= used_now;
            ok_reg   <= ok_next;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                aligned_reg[i] <= aligned_next[i];
            end
        end
    end

    ffba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_TYPES)
    ) u_ptr_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (tidx),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (q_head.mem_type[TIDX_W-1:0]),
        .rd_data (rd_row)
    );

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

/* hdl/first_fit_block_bump_allocator_core.sv */
// Each request passes the request queue, then the back end reads, compares and writes back
// the type's row of block pointers in the pointer memory; it takes the next request from the
// queue only after write-back, and waits in write-back while the master side stalls.
// Reset (aresetn low, synchronous) empties every type's block list, the request queue
// and the output valid flag; the pointer memory is not cleared and needs no clearing pass.
module first_fit_block_bump_allocator_core #(
    parameter int NUM_TYPES  = ffba_pkg::DEF_NUM_TYPES,
    parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_SIZE = ffba_pkg::DEF_BLOCK_SIZE
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mem_type[4:0], alignment[21:5], request_bytes[50:22], zero fill[55:51]
    input  logic [ffba_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // block_index[3:0], byte_offset[31:4], opened_block[32], failed[33], zero fill[39:34]
    output logic [ffba_pkg::M_TDATA_W-1:0] m_tdata
);

    import ffba_pkg::*;

    logic    push;
    logic    pop;
    req_t    push_data;
    req_t    head;
    q_stat_t q_stat;
    result_t result;

    ffba_front #(
        .NUM_TYPES  (NUM_TYPES),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    ffba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    ffba_back #(
        .NUM_TYPES  (NUM_TYPES),
        .MAX_BLOCKS (MAX_BLOCKS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_head   (head),
        .q_pop    (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {6'b0, result.failed, result.opened_block,
                      result.byte_offset, result.block_index};

    // A refused request carries no placement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.failed) |-> (m_tdata[32:0] == 33'd0))
        else $error("failed result carries a placement");

    // A freshly opened block always starts at offset zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.opened_block) |-> (result.byte_offset == '0 && !result.failed))
        else $error("opened block with non-zero offset");

    // The queue is never pushed while full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !push)
        else $error("request queue overrun");

    // The queue is only popped when it holds a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_stat.valid)
        else $error("request queue underrun");

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int          NUM_TYPES   = DEF_NUM_TYPES;
    localparam int          MAX_BLOCKS  = DEF_MAX_BLOCKS;
    localparam bit [29:0]   BLOCK_BYTES = 30'(DEF_BLOCK_SIZE);
    localparam int          RANDOM_REQS = 1325;
    localparam int          HOLD_AFTER  = 400;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 12;

    typedef struct {
        bit [TYPE_W-1:0]  mtype;
        bit [ALIGN_W-1:0] align;
        bit [REQ_W-1:0]   nbytes;
        bit               drain;
    } alloc_req_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alloc_req_t alloc_queue[$];
    result_t    expected_allocs[$];

    // Own copy of the allocator state: block count per type and bump pointer per block.
    bit [4:0]       blocks_open[NUM_TYPES];
    bit [REQ_W-1:0] block_top[NUM_TYPES*MAX_BLOCKS];

    int  mismatches   = 0;
    int  inputs_taken = 0;
    bit  took         = 1'b0;
    int  burst_left   = 0;
    int  gap_left     = 0;
    int  rx_mode      = 0;
    int  rx_left      = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    first_fit_block_bump_allocator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic result_t predict_allocation(bit [TYPE_W-1:0] mtype,
                                                   bit [ALIGN_W-1:0] align_in,
                                                   bit [REQ_W-1:0] nbytes);
        result_t   r;
        bit [ALIGN_W-1:0] align;
        bit [29:0] size;
        bit [29:0] mask;
        bit [29:0] aligned;
        int        used;
        int        slot;
        bit        found;
        r = '0;
        // The highest set bit gives the alignment; zero means byte alignment.
        align = ALIGN_W'(1);
        for (int b = 0; b < ALIGN_W; b++) begin
            if (align_in[b]) begin
                align = ALIGN_W'(1) << b;
            end
        end
        size = (nbytes == 0) ? 30'd1 : {1'b0, nbytes};
        mask = 30'(align) - 30'd1;
        if (int'(mtype) >= NUM_TYPES || size > BLOCK_BYTES) begin
            r.failed = 1'b1;
            return r;
        end
        used  = blocks_open[mtype];
        found = 1'b0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (!found && i < used) begin
                slot    = int'(mtype) * MAX_BLOCKS + i;
                aligned = ({1'b0, block_top[slot]} + mask) & ~mask;
                if (aligned <= BLOCK_BYTES && BLOCK_BYTES - aligned >= size) begin
                    block_top[slot] = REQ_W'(aligned + size);
                    r.block_index   = INDEX_W'(i);
                    r.byte_offset   = aligned[OFFSET_W-1:0];
                    found           = 1'b1;
                end
            end
        end
        if (!found) begin
            if (used >= MAX_BLOCKS) begin
                r.failed = 1'b1;
            end else begin
                block_top[int'(mtype) * MAX_BLOCKS + used] = size[REQ_W-1:0];
                blocks_open[mtype] = 5'(used + 1);
                r.block_index  = INDEX_W'(used);
                r.opened_block = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void add_request(int mtype, int align, int nbytes, bit drain);
        alloc_req_t q;
        q.mtype  = TYPE_W'(mtype);
        q.align  = ALIGN_W'(align);
        q.nbytes = REQ_W'(nbytes);
        q.drain  = drain;
        alloc_queue = {alloc_queue, q};
    endfunction

    // Accepted requests are predicted at the edge that takes them.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            expected_allocs = {expected_allocs,
                               predict_allocation(alloc_queue[0].mtype,
                                                  alloc_queue[0].align,
                                                  alloc_queue[0].nbytes)};
            void'(alloc_queue.pop_front());
            inputs_taken++;
            took = 1'b1;
        end
    end

    always @(negedge aclk) begin : drive_requests
        logic offer;
        offer = 1'b0;
        if (aresetn) begin
            if (s_tvalid && !took) begin
                offer = 1'b1;
            end else if (alloc_queue.size() == 0) begin
                offer = 1'b0;
            end else if (alloc_queue[0].drain && expected_allocs.size() != 0) begin
                offer = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else begin
                offer = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
        took = 1'b0;
        s_tvalid <= offer;
        if (offer) begin
            s_tdata <= {5'd0, alloc_queue[0].nbytes, alloc_queue[0].align, alloc_queue[0].mtype};
        end
    end

    // The receiver stalls in phases of its own, and once holds off for a long stretch.
    always @(negedge aclk) begin : drive_ready
        logic ready;
        ready = 1'b0;
        if (aresetn) begin
            if (!hold_done && inputs_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(10, 150);
            end else begin
                rx_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                case (rx_mode)
                    0: begin
                        ready = 1'b1;
                    end
                    1: begin
                        ready = ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        ready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
        m_tready <= ready;
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (m_tvalid && m_tready) begin
            if (expected_allocs.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result transaction: tdata=%h", m_tdata);
                end
                mismatches++;
            end else begin
                want = expected_allocs.pop_front();
                if (m_tdata[3:0] !== want.block_index || m_tdata[31:4] !== want.byte_offset ||
                    m_tdata[32] !== want.opened_block || m_tdata[33] !== want.failed) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected idx=%0d off=%h open=%b fail=%b",
                                 want.block_index, want.byte_offset, want.opened_block,
                                 want.failed);
                        $display("          got      idx=%0d off=%h open=%b fail=%b",
                                 m_tdata[3:0], m_tdata[31:4], m_tdata[32], m_tdata[33]);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : run
        int pick;
        int mtype;
        int align;
        int nbytes;
        for (int t = 0; t < NUM_TYPES; t++) begin
            blocks_open[t] = '0;
        end

        // Zero size and zero alignment, then a non-power-of-two alignment on the same block.
        add_request(0, 0, 0, 1'b0);
        add_request(0, 3, 3, 1'b0);
        // A full-block request cannot fit behind the first one and opens a second block.
        add_request(0, 65536, 1 << 28, 1'b0);
        add_request(0, 17'h1FFFF, 1, 1'b0);
        add_request(0, 65536, 12345, 1'b0);
        // Oversize requests are refused; a request of exactly the block size is taken.
        add_request(1, 1, (1 << 28) + 1, 1'b0);
        add_request(1, 16, 29'h1FFFFFFF, 1'b0);
        add_request(1, 1, 1 << 28, 1'b0);
        // Fill every block of the last type, then ask again: the list is full.
        for (int i = 0; i < MAX_BLOCKS + 1; i++) begin
            add_request(31, 4096, 1 << 28, 1'b0);
        end
        add_request(31, 1, 1, 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            mtype = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 31);
            align = ($urandom_range(0, 99) < 85) ? (1 << $urandom_range(0, 16))
                                                 : $urandom_range(0, 17'h1FFFF);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                nbytes = $urandom_range(0, 4096);
            end else if (pick < 75) begin
                nbytes = $urandom_range(1, 1 << 20);
            end else if (pick < 90) begin
                nbytes = $urandom_range(1 << 24, 1 << 28);
            end else if (pick < 93) begin
                nbytes = 1 << 28;
            end else begin
                nbytes = $urandom() & 32'h1FFFFFFF;
            end
            // The first random request and one in the middle wait for the pipeline to empty.
            add_request(mtype, align, nbytes, (n == 0) || (n == 800));
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (alloc_queue.size() != 0 || expected_allocs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);

        if (mismatches == 0 && expected_allocs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* first_fit_block_bump_allocator_core.f */
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_queue.sv
hdl/ffba_front.sv
hdl/ffba_back.sv
hdl/first_fit_block_bump_allocator_core.sv
dv/testbench.sv
